// ----- rtl/core/ogru_pkg.sv -----
// ----------------------------------------------------------------------------
// ogru_pkg
// Shared types, constants and codes of the occupancy grid ray update unit.
// ----------------------------------------------------------------------------
package ogru_pkg;

  // grid geometry
  localparam int GRID_SIDE = 256;
  localparam int CW        = $clog2(GRID_SIDE);
  localparam int CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int AW        = $clog2(CELLS);
  localparam int WALK_W    = $clog2(GRID_SIDE + 1);
  localparam int ERR_W     = CW + 3;
  localparam int RAM_W     = 10;

  // evidence limits
  localparam logic [6:0] LIMIT_MAX = 7'd124;

  // map state codes
  localparam logic [1:0] MAP_UNKNOWN = 2'd0;
  localparam logic [1:0] MAP_FREE    = 2'd1;
  localparam logic [1:0] MAP_OCC     = 2'd2;

  // register indexes
  localparam logic [2:0] REG_ORG_X   = 3'd0;
  localparam logic [2:0] REG_ORG_Y   = 3'd1;
  localparam logic [2:0] REG_CPM     = 3'd2;
  localparam logic [2:0] REG_FREE_TH = 3'd3;
  localparam logic [2:0] REG_OCC_TH  = 3'd4;
  localparam logic [2:0] REG_LIMIT   = 3'd5;

  typedef enum logic [1:0] {
    OP_BEAM   = 2'd0,
    OP_FINISH = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CONV,
    ST_CHECK,
    ST_WRD,
    ST_WWR,
    ST_SWEEP,
    ST_SWEEP_END,
    ST_RD,
    ST_RDWAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [23:0] robot_x;
    logic signed [23:0] robot_y;
    logic signed [23:0] hit_x;
    logic signed [23:0] hit_y;
    logic [7:0]         cell_row;
    logic [7:0]         cell_col;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [1:0]        map_value;
    logic signed [7:0] evidence_value;
    logic [8:0]        cells_walked;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic conv_en;
    logic walk_init;
    logic walk_rd;
    logic walk_wr;
    logic sweep_rd;
    logic clr_wr;
    logic rd_issue;
    logic rd_capture;
    logic set_skip;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic skip;
    logic walk_end;
    logic sw_last;
  } sts_t;

  typedef struct packed {
    logic signed [23:0] org_x;
    logic signed [23:0] org_y;
    logic [15:0]        cpm;
    logic [6:0]         free_th;
    logic signed [7:0]  occ_th;
    logic [6:0]         limit;
  } cfg_t;

endpackage

// ----- rtl/core/occupancy_grid_ray_update_unit.sv -----
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update_unit
// Occupancy grid kept in RAM, updated by beams walked cell by cell.
// ----------------------------------------------------------------------------
// Usage:
//   in channel: an item is taken when start is high and busy is low. opcode
//   selects a beam update, a finish sweep or a single cell read.
//   out channel: one result beat per item, shown for exactly one cycle with
//   out_valid high; the receiver cannot stall it and must take it then.
//   config: APB-style port, registers at byte addresses 4*i; the user must
//   write them only while busy is low, as the block does not enforce it.
// Sequence (accept to result strobe):
//   beam: cell conversion on one shared multiplier, a check state, then
//     a RAM read and a RAM write per walked cell, then the result; a
//     skipped beam goes from the check straight to the result.
//   finish: one RAM read and write-back per cell, then the result.
//   read: one RAM read of the addressed cell. Unused opcode: result only.
//   one item is in flight at a time; the grid RAM port sets the pace.
// Reset: registers return to their defaults and a clearing pass writes every
//   one of the 65536 cells to zero, one per cycle; busy stays high meanwhile.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_update_unit import ogru_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  // result channel
  output logic        out_valid,
  output out_item_t   out_item,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.org_x   <= '0;
      cfg_r.org_y   <= '0;
      cfg_r.cpm     <= 16'd5120;
      cfg_r.free_th <= 7'd50;
      cfg_r.occ_th  <= -8'sd50;
      cfg_r.limit   <= 7'd124;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_ORG_X:   cfg_r.org_x   <= pwdata[23:0];
        REG_ORG_Y:   cfg_r.org_y   <= pwdata[23:0];
        REG_CPM:     cfg_r.cpm     <= pwdata[15:0];
        REG_FREE_TH: cfg_r.free_th <= pwdata[6:0];
        REG_OCC_TH:  cfg_r.occ_th  <= pwdata[7:0];
        REG_LIMIT:   cfg_r.limit   <= pwdata[6:0];
        default:     ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      REG_ORG_X:   prdata = {8'd0, cfg_r.org_x};
      REG_ORG_Y:   prdata = {8'd0, cfg_r.org_y};
      REG_CPM:     prdata = {16'd0, cfg_r.cpm};
      REG_FREE_TH: prdata = {25'd0, cfg_r.free_th};
      REG_OCC_TH:  prdata = {24'd0, cfg_r.occ_th};
      REG_LIMIT:   prdata = {25'd0, cfg_r.limit};
      default:     prdata = '0;
    endcase
  end

  ogru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .opcode    (in_item.opcode),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ogru_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .cfg      (cfg_r),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

// ----- rtl/core/ogru_ram.sv -----
// ----------------------------------------------------------------------------
// ogru_ram
// Generic single write, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ogru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/ogru_ctrl.sv -----
// ----------------------------------------------------------------------------
// ogru_ctrl
// Sequencer of the ray update unit: clear pass, beam walk, sweep and read.
// ----------------------------------------------------------------------------
module ogru_ctrl import ogru_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] opcode,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic       busy,
  output logic       out_valid
);

  state_t st_r, st_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR:     if (sts.sw_last) st_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          case (opcode_t'(opcode))
            OP_BEAM:   st_nxt = ST_CONV;
            OP_FINISH: st_nxt = ST_SWEEP;
            OP_READ:   st_nxt = ST_RD;
            default:   st_nxt = ST_DONE;
          endcase
        end
      end
      ST_CONV:      if (sts.conv_done) st_nxt = ST_CHECK;
      ST_CHECK:     st_nxt = sts.skip ? ST_DONE : ST_WRD;
      ST_WRD:       st_nxt = ST_WWR;
      ST_WWR:       st_nxt = sts.walk_end ? ST_DONE : ST_WRD;
      ST_SWEEP:     if (sts.sw_last) st_nxt = ST_SWEEP_END;
      ST_SWEEP_END: st_nxt = ST_DONE;
      ST_RD:        st_nxt = ST_RDWAIT;
      ST_RDWAIT:    st_nxt = ST_DONE;
      ST_DONE:      st_nxt = ST_IDLE;
      default:      st_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (st_r)
      ST_CLEAR:  cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CONV:   cmd.conv_en = 1'b1;
      ST_CHECK: begin
        cmd.set_skip  = sts.skip;
        cmd.walk_init = !sts.skip;
      end
      ST_WRD:    cmd.walk_rd = 1'b1;
      ST_WWR:    cmd.walk_wr = 1'b1;
      ST_SWEEP:  cmd.sweep_rd = 1'b1;
      ST_RD:     cmd.rd_issue = 1'b1;
      ST_RDWAIT: cmd.rd_capture = 1'b1;
      ST_DONE:   out_valid = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  // a result lasts exactly one cycle
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  // an accepted item keeps the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  // last walk write is followed by the result
  a_walk_result: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_WWR && sts.walk_end) |=> out_valid)
    else $error("walk end without result");

endmodule

// ----- rtl/core/ogru_dp.sv -----
// ----------------------------------------------------------------------------
// ogru_dp
// Datapath: cell conversion, line walk, counter update, sweep and grid RAM.
// ----------------------------------------------------------------------------
module ogru_dp import ogru_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  input  in_item_t  in_item,
  input  cfg_t      cfg,
  output sts_t      sts,
  output out_item_t out_item
);

  // captured item
  in_item_t in_r;

  // conversion pipeline
  logic [2:0]    conv_cnt_r;
  logic [24:0]   abs_r;
  logic [CW-1:0] cell_r [4];
  logic [3:0]    oob_r;
  logic signed [23:0] pos_sel, org_sel;
  logic signed [25:0] sum;
  logic [24:0]   abs_nxt;
  logic [40:0]   prod;
  logic [24:0]   full_cell;

  // walk state
  logic [CW-1:0]           r_r, c_r;
  logic [CW-1:0]           re_r, ce_r;
  logic                    sr_r, sc_r;
  logic [CW-1:0]           dr_r;
  logic signed [ERR_W-1:0] dcn_r, err_r;
  logic [WALK_W-1:0]       n_r;
  logic signed [ERR_W:0]   e2;
  logic signed [ERR_W-1:0] err_nxt;
  logic                    step_r, step_c;

  // sweep / clear address
  logic [AW-1:0] sw_addr_r, sw_wa_r;
  logic          pend_r;

  // result
  logic              status_r;
  logic [1:0]        map_r;
  logic signed [7:0] ev_r;
  logic              rd_ok_r;

  // ram ports
  logic             we;
  logic [AW-1:0]    waddr, raddr, walk_addr, rd_addr;
  logic [RAM_W-1:0] wdata, rdata;

  // evidence math
  logic [6:0]        lim;
  logic signed [8:0] v9, lim9, upd9;
  logic [1:0]        sweep_state;

  // capture item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_item;
    end
  end

  // conversion: abs of offset sum, then scale
  always_comb begin
    case (conv_cnt_r[1:0])
      2'd0:    begin pos_sel = in_r.robot_x; org_sel = cfg.org_x; end
      2'd1:    begin pos_sel = in_r.robot_y; org_sel = cfg.org_y; end
      2'd2:    begin pos_sel = in_r.hit_x;   org_sel = cfg.org_x; end
      default: begin pos_sel = in_r.hit_y;   org_sel = cfg.org_y; end
    endcase
    sum       = 26'(pos_sel) + 26'(org_sel);
    abs_nxt   = sum[25] ? 25'(-sum) : sum[24:0];
    prod      = 41'(abs_r) * 41'(cfg.cpm);
    full_cell = prod[40:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      conv_cnt_r <= '0;
    end else if (cmd.conv_en) begin
      conv_cnt_r <= conv_cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.conv_en) begin
      abs_r <= abs_nxt;
      if (conv_cnt_r != 3'd0) begin
        cell_r[2'(conv_cnt_r - 3'd1)] <= full_cell[CW-1:0];
        oob_r[2'(conv_cnt_r - 3'd1)]  <= (full_cell >= 25'(GRID_SIDE));
      end
    end
  end

  // bresenham step
  always_comb begin
    e2      = {err_r, 1'b0};
    step_r  = (e2 >= (ERR_W+1)'(dcn_r));
    step_c  = (e2 <= $signed((ERR_W+1)'(dr_r)));
    err_nxt = err_r;
    if (step_r) err_nxt = err_nxt + dcn_r;
    if (step_c) err_nxt = err_nxt + $signed(ERR_W'(dr_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      r_r   <= cell_r[0];
      c_r   <= cell_r[1];
      re_r  <= cell_r[2];
      ce_r  <= cell_r[3];
      sr_r  <= cell_r[0] < cell_r[2];
      sc_r  <= cell_r[1] < cell_r[3];
      dr_r  <= (cell_r[2] > cell_r[0]) ? cell_r[2] - cell_r[0] : cell_r[0] - cell_r[2];
      dcn_r <= (cell_r[3] > cell_r[1]) ? $signed(ERR_W'(cell_r[1])) - $signed(ERR_W'(cell_r[3]))
                                       : $signed(ERR_W'(cell_r[3])) - $signed(ERR_W'(cell_r[1]));
      err_r <= ((cell_r[2] > cell_r[0]) ? $signed(ERR_W'(cell_r[2] - cell_r[0]))
                                        : $signed(ERR_W'(cell_r[0] - cell_r[2])))
             + ((cell_r[3] > cell_r[1]) ? $signed(ERR_W'(cell_r[1])) - $signed(ERR_W'(cell_r[3]))
                                        : $signed(ERR_W'(cell_r[3])) - $signed(ERR_W'(cell_r[1])));
    end else if (cmd.walk_wr && !sts.walk_end) begin
      err_r <= err_nxt;
      if (step_r) r_r <= sr_r ? r_r + CW'(1) : r_r - CW'(1);
      if (step_c) c_r <= sc_r ? c_r + CW'(1) : c_r - CW'(1);
    end
  end

  // cells walked
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      n_r <= '0;
    end else if (cmd.walk_wr) begin
      n_r <= n_r + WALK_W'(1);
    end
  end

  // sweep and clear address counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_addr_r <= '0;
      pend_r    <= 1'b0;
    end else begin
      pend_r <= cmd.sweep_rd;
      if (cmd.sweep_rd || cmd.clr_wr) begin
        sw_addr_r <= sts.sw_last ? '0 : sw_addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    sw_wa_r <= sw_addr_r;
  end

  // evidence update and finish state
  always_comb begin
    lim  = (cfg.limit > LIMIT_MAX) ? LIMIT_MAX : cfg.limit;
    lim9 = $signed({2'b00, lim});
    v9   = 9'(signed'(rdata[7:0]));
    if (sts.walk_end) begin
      upd9 = (v9 < -lim9) ? -lim9 : v9 - 9'sd1;
    end else begin
      upd9 = (v9 > lim9) ? lim9 : v9 + 9'sd1;
    end
    if (v9 >= $signed({2'b00, cfg.free_th})) begin
      sweep_state = MAP_FREE;
    end else if (v9 <= 9'(cfg.occ_th)) begin
      sweep_state = MAP_OCC;
    end else begin
      sweep_state = rdata[9:8];
    end
  end

  // ram port selection
  always_comb begin
    walk_addr = AW'(int'(r_r) * GRID_SIDE + int'(c_r));
    rd_addr   = AW'(int'(CW'(in_r.cell_row)) * GRID_SIDE + int'(CW'(in_r.cell_col)));
    we        = cmd.clr_wr | cmd.walk_wr | pend_r;
    waddr     = sw_addr_r;
    wdata     = '0;
    if (cmd.walk_wr) begin
      waddr = walk_addr;
      wdata = {sts.walk_end ? MAP_OCC : MAP_FREE, upd9[7:0]};
    end else if (pend_r) begin
      waddr = sw_wa_r;
      wdata = {sweep_state, rdata[7:0]};
    end
    raddr = sw_addr_r;
    if (cmd.walk_rd) begin
      raddr = walk_addr;
    end else if (cmd.rd_issue) begin
      raddr = rd_addr;
    end
  end

  ogru_ram #(
    .WIDTH (RAM_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r <= 1'b0;
      map_r    <= MAP_UNKNOWN;
      ev_r     <= '0;
      rd_ok_r  <= (int'(in_item.cell_row) < GRID_SIDE) && (int'(in_item.cell_col) < GRID_SIDE);
    end else begin
      if (cmd.set_skip) status_r <= 1'b1;
      if (cmd.rd_capture && rd_ok_r) begin
        map_r <= rdata[9:8];
        ev_r  <= signed'(rdata[7:0]);
      end
    end
  end

  // status to the sequencer
  always_comb begin
    sts.conv_done = (conv_cnt_r == 3'd4);
    sts.skip      = |oob_r;
    sts.walk_end  = (r_r == re_r) && (c_r == ce_r);
    sts.sw_last   = (sw_addr_r == AW'(CELLS - 1));
  end

  assign out_item.status         = status_r;
  assign out_item.map_value      = map_r;
  assign out_item.evidence_value = ev_r;
  assign out_item.cells_walked   = 9'(n_r);

  // walk never visits more than one side of cells
  a_walk_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_wr |-> (n_r < WALK_W'(GRID_SIDE))) else $error("walk too long");

  // sweep write-back never collides with a walk or clear write
  a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !(cmd.walk_wr || cmd.clr_wr)) else $error("ram write collision");

  // conversion counter stops at the last multiply
  a_conv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.conv_en |-> (conv_cnt_r <= 3'd4)) else $error("conversion overrun");

endmodule
